>>> rtl/top_of_book_quote_updater_top_macros.svh
// ---------------------------------------------------------------------------
// Top-of-book quote updater assertion macros
// Concurrent assertion helpers shared by the RTL, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef TOP_OF_BOOK_QUOTE_UPDATER_TOP_MACROS_SVH
`define TOP_OF_BOOK_QUOTE_UPDATER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define TOBQU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tobqu assertion failed");

// Next-cycle implication, disabled during reset.
`define TOBQU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tobqu assertion failed");

`else

`define TOBQU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TOBQU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/tobqu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Top-of-book quote updater package
// Table geometry, message and result codes, entry layout and side packing.
// ---------------------------------------------------------------------------
package tobqu_pkg;

    // Table geometry.
    localparam int SLOTS  = 4096;
    localparam int SLOT_W = $clog2(SLOTS);

    // Scaling constants.
    localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;
    localparam logic [6:0]  SHORT_SCALE   = 7'd100;

    // Message commands.
    localparam logic [3:0] CMD_TIME       = 4'd0;
    localparam logic [3:0] CMD_SYSTEM     = 4'd1;
    localparam logic [3:0] CMD_DIRECTORY  = 4'd2;
    localparam logic [3:0] CMD_BOTH_LONG  = 4'd3;
    localparam logic [3:0] CMD_BOTH_SHORT = 4'd4;
    localparam logic [3:0] CMD_BID_LONG   = 4'd5;
    localparam logic [3:0] CMD_BID_SHORT  = 4'd6;
    localparam logic [3:0] CMD_ASK_LONG   = 4'd7;
    localparam logic [3:0] CMD_ASK_SHORT  = 4'd8;
    localparam logic [3:0] CMD_TRADE      = 4'd9;
    localparam logic [3:0] CMD_BROKEN     = 4'd10;
    localparam logic [3:0] CMD_ACTION     = 4'd11;
    localparam logic [3:0] CMD_OPEN       = 4'd12;

    // Run modes.
    localparam logic [1:0] MODE_DEFS = 2'd0;
    localparam logic [1:0] MODE_SNAP = 2'd1;
    localparam logic [1:0] MODE_LIVE = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_QUOTE    = 2'd0;
    localparam logic [1:0] KIND_TRADE    = 2'd1;
    localparam logic [1:0] KIND_DEFS_END = 2'd2;

    // Trading status codes.
    localparam logic [1:0] TS_NORMAL = 2'd0;
    localparam logic [1:0] TS_HALTED = 2'd1;
    localparam logic [1:0] TS_CLOSED = 2'd2;

    // One side of the book: price and size.
    typedef struct packed {
        logic [31:0] price;
        logic [31:0] size;
    } side_t;

    // One table entry: both sides with their stamps, open flag and status.
    typedef struct packed {
        side_t       bid;
        logic [62:0] bid_stamp;
        side_t       ask;
        logic [62:0] ask_stamp;
        logic        open;
        logic [1:0]  status;
    } tob_entry_t;

    // Builds a side from message fields; short form keeps 16 bits and
    // scales the price by one hundred.
    function automatic side_t make_side(input logic [31:0] price,
                                        input logic [31:0] size,
                                        input logic        short_form);
        side_t       s;
        logic [22:0] scaled;
        scaled = 23'(price[15:0]) * 23'(SHORT_SCALE);
        if (short_form)
        begin
            s.price = {9'd0, scaled};
            s.size  = {16'd0, size[15:0]};
        end
        else
        begin
            s.price = price;
            s.size  = size;
        end
        return s;
    endfunction

endpackage

>>> rtl/top_of_book_quote_updater_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Top-of-book quote updater
// Per-security bid/ask table updated from decoded feed messages.
// ---------------------------------------------------------------------------
// Usage:
// Messages enter on the input channel (in_valid/in_ready) with one port per
// field; results leave on the output channel (out_valid/out_ready). The
// run_mode register is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce. Each
// message reads its entry of a single table memory with a registered read
// when it is accepted; in ST_EXEC the update, the write-back (only if the
// entry changes) and the loading of the result happen together. A message
// is accepted only in ST_IDLE, after the previous one is written back, so
// no message is taken before the last is through and no forwarding is
// needed. After reset the table is swept to its reset value, one slot per
// cycle, over all 4096 slots; no message is accepted during that sweep,
// while config writes are taken. When the receiver stalls, one finished
// result waits in the output register; the following message is accepted
// and read, and its update is held until the output register frees up.
// ---------------------------------------------------------------------------
`include "top_of_book_quote_updater_top_macros.svh"

module top_of_book_quote_updater_top
    import tobqu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    // Message input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           command,
    input  logic                 security_known,
    input  logic [SLOT_W-1:0]    security_slot,
    input  logic [29:0]          ns_offset,
    input  logic [31:0]          seconds,
    input  logic [31:0]          bid_qty,
    input  logic [31:0]          bid_px,
    input  logic [31:0]          ask_qty,
    input  logic [31:0]          ask_px,
    input  logic                 state_flag,
    input  logic [7:0]           trade_cond,
    input  logic [63:0]          sequence_req,
    // Result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [SLOT_W-1:0]    out_slot,
    output logic [63:0]          out_sequence,
    output logic [61:0]          event_time,
    output logic [22:0]          out_bid_px,
    output logic [31:0]          out_bid_qty,
    output logic [31:0]          out_ask_px,
    output logic [31:0]          out_ask_qty,
    output logic [1:0]           trading_status,
    output logic [7:0]           out_condition
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    logic [1:0]          run_mode_reg;
    logic [62:0]         base_time_reg;
    logic                clearing_reg;
    logic [SLOT_W-1:0]   clr_cnt_reg;

    // Latched message.
    logic [3:0]          cmd_reg;
    logic                known_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [62:0]         ts_reg;
    side_t               bid_side_reg;
    side_t               ask_side_reg;
    logic                flag_reg;
    logic [7:0]          cond_reg;
    logic [63:0]         seq_reg;

    // Table memory.
    tob_entry_t          tob_mem [SLOTS];
    tob_entry_t          rd_q_reg;
    logic [SLOT_W-1:0]   rd_addr;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    tob_entry_t          mem_wdata;
    tob_entry_t          reset_entry;

    // Execute-stage results.
    logic                accept;
    logic                proceed;
    logic                bid_ok;
    logic                ask_ok;
    logic                changed;
    logic                emit_trade;
    logic                emit_defs;
    logic                emit_quote;
    tob_entry_t          new_entry;
    logic                short_form;
    side_t               bid_fields_side;
    side_t               ask_fields_side;

    // Output registers.
    logic                out_valid_reg;
    logic [1:0]          kind_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [63:0]         out_seq_reg;
    logic [61:0]         event_time_reg;
    logic [22:0]         out_bid_px_reg;
    logic [31:0]         out_bid_qty_reg;
    logic [31:0]         out_ask_px_reg;
    logic [31:0]         out_ask_qty_reg;
    logic [1:0]          status_out_reg;
    logic [7:0]          out_cond_reg;

    // Handshake.
    assign in_ready = (state_reg == ST_IDLE) && !clearing_reg;
    assign accept   = in_valid && in_ready;
    assign proceed  = !out_valid_reg || out_ready;

    // Side values from the message fields; single-sided ask updates carry
    // their values in the bid fields.
    assign short_form = (command == CMD_BOTH_SHORT) || (command == CMD_BID_SHORT)
                     || (command == CMD_ASK_SHORT);
    assign bid_fields_side = make_side(bid_px, bid_qty, short_form);
    assign ask_fields_side = make_side(ask_px, ask_qty, short_form);

    // Configuration register and base time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg  <= MODE_LIVE;
            base_time_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                run_mode_reg <= cfg_wr_data;
            end
            if (accept && run_mode_reg != MODE_DEFS && command == CMD_TIME)
            begin
                base_time_reg <= {31'd0, seconds} * {33'd0, NS_PER_SECOND};
            end
        end
    end

    // Message latch at accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            known_reg <= security_known;
            slot_reg  <= security_slot;
            ts_reg    <= base_time_reg + 63'(ns_offset);
            flag_reg  <= state_flag;
            cond_reg  <= trade_cond;
            seq_reg   <= sequence_req;
            bid_side_reg <= bid_fields_side;
            if (command == CMD_ASK_LONG || command == CMD_ASK_SHORT)
            begin
                ask_side_reg <= bid_fields_side;
            end
            else
            begin
                ask_side_reg <= ask_fields_side;
            end
        end
    end

    // Clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            if (clr_cnt_reg == SLOT_W'(SLOTS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Reset value of one table entry.
    always_comb
    begin
        reset_entry        = '0;
        reset_entry.status = TS_CLOSED;
    end

    // Table update for the latched message.
    always_comb
    begin
        bid_ok     = ts_reg >= rd_q_reg.bid_stamp;
        ask_ok     = ts_reg >= rd_q_reg.ask_stamp;
        new_entry  = rd_q_reg;
        changed    = 1'b0;
        emit_trade = 1'b0;
        emit_defs  = 1'b0;
        if (run_mode_reg == MODE_DEFS)
        begin
            emit_defs = (cmd_reg >= CMD_BOTH_LONG) && (cmd_reg <= CMD_ASK_SHORT);
        end
        else if (known_reg)
        begin
            case (cmd_reg) inside
                CMD_BOTH_LONG, CMD_BOTH_SHORT:
                begin
                    changed = bid_ok || ask_ok;
                    if (bid_ok)
                    begin
                        new_entry.bid       = bid_side_reg;
                        new_entry.bid_stamp = ts_reg;
                    end
                    if (ask_ok)
                    begin
                        new_entry.ask       = ask_side_reg;
                        new_entry.ask_stamp = ts_reg;
                    end
                end
                CMD_BID_LONG, CMD_BID_SHORT:
                begin
                    changed = bid_ok;
                    new_entry.bid       = bid_side_reg;
                    new_entry.bid_stamp = ts_reg;
                end
                CMD_ASK_LONG, CMD_ASK_SHORT:
                begin
                    changed = ask_ok;
                    new_entry.ask       = ask_side_reg;
                    new_entry.ask_stamp = ts_reg;
                end
                CMD_TRADE:
                begin
                    emit_trade = 1'b1;
                end
                CMD_ACTION:
                begin
                    changed = 1'b1;
                    if (flag_reg)
                    begin
                        new_entry.status = TS_HALTED;
                    end
                    else if (rd_q_reg.open)
                    begin
                        new_entry.status = TS_NORMAL;
                    end
                    else
                    begin
                        new_entry.status = TS_CLOSED;
                    end
                end
                CMD_OPEN:
                begin
                    changed        = 1'b1;
                    new_entry.open = flag_reg;
                    new_entry.status = flag_reg ? TS_NORMAL : TS_CLOSED;
                end
                default:
                begin
                    changed = 1'b0;
                end
            endcase
        end
        emit_quote = changed && (run_mode_reg != MODE_SNAP);
    end

    // Memory port control.
    assign rd_addr   = (state_reg == ST_IDLE) ? security_slot : slot_reg;
    assign mem_we    = clearing_reg || ((state_reg == ST_EXEC) && proceed && changed);
    assign mem_waddr = clearing_reg ? clr_cnt_reg : slot_reg;
    assign mem_wdata = clearing_reg ? reset_entry : new_entry;

    // Table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tob_mem[mem_waddr] <= mem_wdata;
        end
        rd_q_reg <= tob_mem[rd_addr];
    end

    // State machine and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (proceed)
                    begin
                        out_valid_reg <= emit_quote || emit_trade || emit_defs;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC && proceed)
        begin
            out_seq_reg     <= seq_reg;
            kind_reg        <= KIND_QUOTE;
            out_slot_reg    <= slot_reg;
            event_time_reg  <= ts_reg[61:0];
            out_bid_px_reg  <= new_entry.bid.price[22:0];
            out_bid_qty_reg <= new_entry.bid.size;
            out_ask_px_reg  <= new_entry.ask.price;
            out_ask_qty_reg <= new_entry.ask.size;
            status_out_reg  <= new_entry.status;
            out_cond_reg    <= '0;
            if (emit_defs)
            begin
                kind_reg        <= KIND_DEFS_END;
                out_slot_reg    <= '0;
                event_time_reg  <= '0;
                out_bid_px_reg  <= '0;
                out_bid_qty_reg <= '0;
                out_ask_px_reg  <= '0;
                out_ask_qty_reg <= '0;
                status_out_reg  <= '0;
            end
            else if (emit_trade)
            begin
                kind_reg        <= KIND_TRADE;
                out_bid_px_reg  <= bid_side_reg.price[22:0];
                out_bid_qty_reg <= bid_side_reg.size;
                out_ask_px_reg  <= '0;
                out_ask_qty_reg <= '0;
                status_out_reg  <= '0;
                out_cond_reg    <= cond_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign out_slot       = out_slot_reg;
    assign out_sequence   = out_seq_reg;
    assign event_time     = event_time_reg;
    assign out_bid_px     = out_bid_px_reg;
    assign out_bid_qty    = out_bid_qty_reg;
    assign out_ask_px     = out_ask_px_reg;
    assign out_ask_qty    = out_ask_qty_reg;
    assign trading_status = status_out_reg;
    assign out_condition  = out_cond_reg;

    // Assertions.
    `TOBQU_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, state_reg == ST_EXEC)
    `TOBQU_ASSERT_NOW(a_clear_quiet, clk, rst_n, clearing_reg,
        state_reg == ST_IDLE && !out_valid_reg)
    `TOBQU_ASSERT_NEXT(a_time_silent, clk, rst_n,
        state_reg == ST_EXEC && proceed && cmd_reg == CMD_TIME, !out_valid_reg)

endmodule
